// File: rtl/core/pmtc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pmtc_pkg;

    localparam int MAC_W    = 48;
    localparam int CNT_W    = 32;
    localparam int LEN_W    = 16;
    localparam int PERIOD_W = 16;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 1;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd60;
    localparam logic [CNT_W-1:0]    STEP_RESET   = 32'd1048576;
    localparam logic [CNT_W-1:0]    CNT_MAX      = '1;

    // request kinds on the input channel
    localparam logic ACT_FRAME = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    // result kinds on the output channel
    localparam logic KIND_MARK   = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_REPORT_PERIOD = 1'b0,
        REG_VOLUME_STEP   = 1'b1
    } cfg_reg_t;

    // command handed from the front to the back
    typedef struct packed {
        logic             is_report;
        logic             mark;
        logic [MAC_W-1:0] dest_mac;
        logic [MAC_W-1:0] src_mac;
        logic [LEN_W-1:0] frame_length;
    } cmd_t;

    // one table row as held in the row memory
    typedef struct packed {
        logic [MAC_W-1:0] mac;
        logic [CNT_W-1:0] bytes_in;
        logic [CNT_W-1:0] bytes_out;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [LEN_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {{(CNT_W-LEN_W+1){1'b0}}, b};
        return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/pmtc_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pmtc_in_if;
    import pmtc_pkg::*;

    logic             valid;
    logic             ready;
    logic             action;
    logic [MAC_W-1:0] dest_mac;
    logic [MAC_W-1:0] src_mac;
    logic [LEN_W-1:0] frame_length;

    modport source (output valid, action, dest_mac, src_mac, frame_length, input ready);
    modport sink   (input valid, action, dest_mac, src_mac, frame_length, output ready);
endinterface

`default_nettype wire

// File: rtl/core/pmtc_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pmtc_out_if;
    import pmtc_pkg::*;

    logic             valid;
    logic             ready;
    logic             kind;
    logic [MAC_W-1:0] entry_mac;
    logic [CNT_W-1:0] bytes_in;
    logic [CNT_W-1:0] bytes_out;
    logic             last;

    modport source (output valid, kind, entry_mac, bytes_in, bytes_out, last, input ready);
    modport sink   (input valid, kind, entry_mac, bytes_in, bytes_out, last, output ready);
endinterface

`default_nettype wire

// File: rtl/core/pmtc_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module pmtc_ram #(
    parameter int WIDTH = 112,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read-first: a read at the written address returns the old word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// File: rtl/core/pmtc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module pmtc_front (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [pmtc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [pmtc_pkg::CFG_W-1:0]         cfg_data,
    pmtc_in_if.sink                                 item,
    input  wire logic                               q_full,
    output logic                                    push,
    output pmtc_pkg::cmd_t                          push_cmd
);
    import pmtc_pkg::*;

    logic [PERIOD_W-1:0] period_reg;
    logic [CNT_W-1:0]    step_reg;
    logic [CNT_W-1:0]    total_reg, total_next;
    logic [PERIOD_W-1:0] tick_reg, tick_next;

    logic                accept;
    logic [CNT_W:0]      sum;
    logic [CNT_W:0]      sum_adj;
    logic                mark;
    logic [PERIOD_W-1:0] tick_inc;
    logic                due;

    assign item.ready = !q_full;
    assign accept     = item.valid && item.ready;

    always_comb
    begin
        sum      = {1'b0, total_reg} + {{(CNT_W-LEN_W+1){1'b0}}, item.frame_length};
        mark     = sum > {1'b0, step_reg};
        sum_adj  = mark ? sum - {1'b0, step_reg} : sum;
        tick_inc = tick_reg + 1'b1;
        due      = tick_inc >= period_reg;

        total_next = total_reg;
        tick_next  = tick_reg;
        if (accept && item.action == ACT_FRAME)
        begin
            total_next = sum_adj[CNT_W] ? CNT_MAX : sum_adj[CNT_W-1:0];
        end
        if (accept && item.action == ACT_TICK)
        begin
            tick_next = due ? tick_inc - period_reg : tick_inc;
        end

        push = accept && (item.action == ACT_FRAME || due);
        push_cmd.is_report    = item.action == ACT_TICK;
        push_cmd.mark         = item.action == ACT_FRAME && mark;
        push_cmd.dest_mac     = item.dest_mac;
        push_cmd.src_mac      = item.src_mac;
        push_cmd.frame_length = item.frame_length;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RESET;
            step_reg   <= STEP_RESET;
            total_reg  <= '0;
            tick_reg   <= '0;
        end
        else
        begin
            total_reg <= total_next;
            tick_reg  <= tick_next;
            if (cfg_we)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_REPORT_PERIOD: period_reg <= cfg_data[PERIOD_W-1:0];
                    REG_VOLUME_STEP:   step_reg   <= cfg_data[CNT_W-1:0];
                    default:           period_reg <= period_reg;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/pmtc_cmd_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module pmtc_cmd_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  pmtc_pkg::cmd_t      push_cmd,
    output logic                full,
    input  wire logic           pop,
    output logic                not_empty,
    output pmtc_pkg::cmd_t      head
);
    import pmtc_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_QW-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full      = count_reg == CNT_QW'(QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign head      = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_QW'(do_push) - CNT_QW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/pmtc_back.sv
`timescale 1ns / 1ps
`default_nettype none

module pmtc_back #(
    parameter int ENTRIES = 16
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       q_valid,
    input  pmtc_pkg::cmd_t  head,
    output logic            pop,
    pmtc_out_if.source      result
);
    import pmtc_pkg::*;

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int FILL_W = $clog2(ENTRIES + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DST,
        S_SRC,
        S_MARK,
        S_REPORT
    } state_t;

    state_t            state_reg, state_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [IDX_W-1:0]  rep_idx_reg, rep_idx_next;

    logic [MAC_W-1:0]  cam_reg [ENTRIES];
    cmd_t              cmd_reg, cmd_next;
    logic [IDX_W-1:0]  d_idx_reg, d_idx_next;
    logic              d_ok_reg, d_ok_next;
    logic              d_new_reg, d_new_next;
    logic [IDX_W-1:0]  s_idx_reg, s_idx_next;
    logic              s_ok_reg, s_ok_next;
    logic              s_new_reg, s_new_next;
    logic              s_same_reg, s_same_next;
    rec_t              fwd_reg, fwd_next;

    logic              out_valid_reg, out_valid_next;
    logic              out_kind_reg, out_kind_next;
    logic [MAC_W-1:0]  out_mac_reg, out_mac_next;
    logic [CNT_W-1:0]  out_in_reg, out_in_next;
    logic [CNT_W-1:0]  out_out_reg, out_out_next;
    logic              out_last_reg, out_last_next;

    logic [MAC_W-1:0]  look_mac;
    logic [ENTRIES-1:0] match;
    logic              hit;
    logic [IDX_W-1:0]  hit_idx;
    logic              can_alloc;
    logic [IDX_W-1:0]  alloc_idx;
    logic              look_ok;
    logic              look_new;
    logic [IDX_W-1:0]  look_idx;

    logic              cam_we;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_wr_addr;
    rec_t              ram_wr_data;
    logic [IDX_W-1:0]  ram_rd_addr;
    logic [REC_W-1:0]  ram_rd_word;
    rec_t              ram_rd_data;
    rec_t              base;
    rec_t              upd;
    logic              slot_free;
    logic              rep_last;

    assign ram_rd_data = rec_t'(ram_rd_word);

    pmtc_ram #(
        .WIDTH (REC_W),
        .DEPTH (ENTRIES)
    ) u_rows (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_word)
    );

    // one shared match unit: destination key when idle, source key otherwise
    always_comb
    begin
        look_mac = (state_reg == S_IDLE) ? head.dest_mac : cmd_reg.src_mac;
        hit_idx  = '0;
        for (int k = 0; k < ENTRIES; k++)
        begin
            match[k] = (FILL_W'(k) < fill_reg) && (cam_reg[k] == look_mac);
        end
        for (int k = 0; k < ENTRIES; k++)
        begin
            if (match[k])
            begin
                hit_idx = IDX_W'(k);
            end
        end
        hit       = |match;
        can_alloc = fill_reg < FILL_W'(ENTRIES);
        alloc_idx = fill_reg[IDX_W-1:0];
        look_ok   = hit || can_alloc;
        look_new  = !hit && can_alloc;
        look_idx  = hit ? hit_idx : alloc_idx;
    end

    assign slot_free = !out_valid_reg || result.ready;
    assign rep_last  = (FILL_W'(rep_idx_reg) + 1'b1) == fill_reg;

    always_comb
    begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        rep_idx_next = rep_idx_reg;
        cmd_next     = cmd_reg;
        d_idx_next   = d_idx_reg;
        d_ok_next    = d_ok_reg;
        d_new_next   = d_new_reg;
        s_idx_next   = s_idx_reg;
        s_ok_next    = s_ok_reg;
        s_new_next   = s_new_reg;
        s_same_next  = s_same_reg;
        fwd_next     = fwd_reg;

        out_valid_next = out_valid_reg && !result.ready;
        out_kind_next  = out_kind_reg;
        out_mac_next   = out_mac_reg;
        out_in_next    = out_in_reg;
        out_out_next   = out_out_reg;
        out_last_next  = out_last_reg;

        pop         = 1'b0;
        cam_we      = 1'b0;
        ram_we      = 1'b0;
        ram_wr_addr = d_idx_reg;
        ram_rd_addr = look_idx;
        base        = ram_rd_data;
        upd         = ram_rd_data;
        ram_wr_data = upd;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    pop      = 1'b1;
                    cmd_next = head;
                    if (head.is_report)
                    begin
                        ram_rd_addr = '0;
                        if (fill_reg != '0)
                        begin
                            rep_idx_next = '0;
                            state_next   = S_REPORT;
                        end
                    end
                    else
                    begin
                        d_ok_next  = look_ok;
                        d_new_next = look_new;
                        d_idx_next = look_idx;
                        if (look_new)
                        begin
                            cam_we    = 1'b1;
                            fill_next = fill_reg + 1'b1;
                        end
                        state_next = S_DST;
                    end
                end
            end
            S_DST:
            begin
                // add to the in count, then look up the source
                base = d_new_reg ? rec_t'{cmd_reg.dest_mac, '0, '0} : ram_rd_data;
                upd  = base;
                upd.bytes_in = sat_add(base.bytes_in, cmd_reg.frame_length);
                ram_we       = d_ok_reg;
                ram_wr_addr  = d_idx_reg;
                ram_wr_data  = upd;
                fwd_next     = upd;
                s_ok_next    = look_ok;
                s_new_next   = look_new;
                s_idx_next   = look_idx;
                s_same_next  = d_ok_reg && hit && (hit_idx == d_idx_reg);
                if (look_new)
                begin
                    cam_we    = 1'b1;
                    fill_next = fill_reg + 1'b1;
                end
                state_next = S_SRC;
            end
            S_SRC:
            begin
                // same row as the destination: the memory read is stale
                if (s_new_reg)
                begin
                    base = rec_t'{cmd_reg.src_mac, '0, '0};
                end
                else if (s_same_reg)
                begin
                    base = fwd_reg;
                end
                else
                begin
                    base = ram_rd_data;
                end
                upd = base;
                upd.bytes_out = sat_add(base.bytes_out, cmd_reg.frame_length);
                ram_we        = s_ok_reg;
                ram_wr_addr   = s_idx_reg;
                ram_wr_data   = upd;
                state_next    = cmd_reg.mark ? S_MARK : S_IDLE;
            end
            S_MARK:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_MARK;
                    out_mac_next   = '0;
                    out_in_next    = '0;
                    out_out_next   = '0;
                    out_last_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_REPORT:
            begin
                ram_rd_addr = rep_idx_reg;
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_REPORT;
                    out_mac_next   = ram_rd_data.mac;
                    out_in_next    = ram_rd_data.bytes_in;
                    out_out_next   = ram_rd_data.bytes_out;
                    out_last_next  = rep_last;
                    rep_idx_next   = rep_idx_reg + 1'b1;
                    ram_rd_addr    = rep_idx_reg + 1'b1;
                    if (rep_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            rep_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_kind_reg  <= KIND_MARK;
            out_mac_reg   <= '0;
            out_in_reg    <= '0;
            out_out_reg   <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            rep_idx_reg   <= rep_idx_next;
            out_valid_reg <= out_valid_next;
            out_kind_reg  <= out_kind_next;
            out_mac_reg   <= out_mac_next;
            out_in_reg    <= out_in_next;
            out_out_reg   <= out_out_next;
            out_last_reg  <= out_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        d_idx_reg  <= d_idx_next;
        d_ok_reg   <= d_ok_next;
        d_new_reg  <= d_new_next;
        s_idx_reg  <= s_idx_next;
        s_ok_reg   <= s_ok_next;
        s_new_reg  <= s_new_next;
        s_same_reg <= s_same_next;
        fwd_reg    <= fwd_next;
        if (cam_we)
        begin
            cam_reg[alloc_idx] <= look_mac;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.kind      = out_kind_reg;
    assign result.entry_mac = out_mac_reg;
    assign result.bytes_in  = out_in_reg;
    assign result.bytes_out = out_out_reg;
    assign result.last      = out_last_reg;

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(ENTRIES))
        else $error("table fill beyond capacity");

    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (fill_reg == $past(fill_reg) || fill_reg == $past(fill_reg) + 1'b1))
        else $error("table fill moved by more than one");

    a_no_write_in_report: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REPORT) |-> !ram_we)
        else $error("row write during report sweep");

    a_same_row: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SRC && s_same_reg) |-> (s_idx_reg == d_idx_reg && !s_new_reg))
        else $error("source forwarding from a different row");
`endif

endmodule

`default_nettype wire

// File: rtl/core/per_mac_traffic_counter_table.sv
`timescale 1ns / 1ps
`default_nettype none

// per-address traffic statistics: a table of up to ENTRIES MAC addresses, each with
// saturating 32-bit byte counts for traffic to it (bytes_in) and from it (bytes_out).
// a frame request looks up its destination, then its source, taking a free row for an
// unknown address (none once the table is full, and that address is then not counted).
// a running byte total gives a volume mark result whenever it passes volume_step; tick
// requests count time and every report_period ticks each valid row is reported in row
// order, last flagged. the front takes one request per cycle while its two-deep command
// queue has room; the back then runs a frame through S_DST and S_SRC (two
// read-modify-writes on the single-read row memory), S_MARK for a volume mark, and a
// report through S_REPORT, one row at a time. ticks that cause no report never reach
// the back. no clearing pass after reset: rows are only read below the fill level.
module per_mac_traffic_counter_table #(
    parameter int ENTRIES = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [pmtc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [pmtc_pkg::CFG_W-1:0]     cfg_data,
    pmtc_in_if.sink                             item,
    pmtc_out_if.source                          result
);
    import pmtc_pkg::*;

    // front to queue
    logic push;
    cmd_t push_cmd;
    logic q_full;

    // queue to back
    logic q_valid;
    cmd_t head;
    logic pop;

    // front: config registers, volume total and tick counter; decides the commands
    pmtc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item),
        .q_full    (q_full),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    // short queue so the front keeps taking requests while the back is busy
    pmtc_cmd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_valid),
        .head      (head)
    );

    // back: address match, row updates, report sweep and the output register
    pmtc_back #(
        .ENTRIES (ENTRIES)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .head    (head),
        .pop     (pop),
        .result  (result)
    );

endmodule

`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import pmtc_pkg::*;

    localparam int ROWS = 16;

    // one result as it leaves the block
    typedef struct packed {
        logic             kind;
        logic [MAC_W-1:0] mac;
        logic [CNT_W-1:0] bytes_in;
        logic [CNT_W-1:0] bytes_out;
        logic             last;
    } traffic_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    pmtc_in_if  item_ch ();
    pmtc_out_if result_ch ();

    per_mac_traffic_counter_table #(
        .ENTRIES (ROWS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_ch),
        .result    (result_ch)
    );

    always #2 clk = ~clk;

    // shadow copy of the address table and its counters
    logic [MAC_W-1:0]    row_mac   [ROWS];
    logic [CNT_W-1:0]    row_in    [ROWS];
    logic [CNT_W-1:0]    row_out   [ROWS];
    int                  rows_used;
    logic [CNT_W-1:0]    volume_sum;
    logic [PERIOD_W-1:0] tick_total;
    logic [PERIOD_W-1:0] period_reg;
    logic [CNT_W-1:0]    step_reg;

    // results still owed by the block, oldest first
    traffic_result_t owed_results [$];

    // run statistics and error count
    int n_errors  = 0;
    int n_frames  = 0;
    int n_ticks   = 0;
    int n_marks   = 0;
    int n_reports = 0;

    // when set both sides run without gaps
    bit tight = 1'b0;

    localparam logic [MAC_W-1:0] MAC_ZERO = '0;
    localparam logic [MAC_W-1:0] MAC_ONES = '1;
    localparam logic [MAC_W-1:0] MAC_A    = 48'h0123_4567_89AB;
    localparam logic [MAC_W-1:0] MAC_B    = 48'hFEDC_BA98_7654;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    task automatic clear_shadow();
        for (int k = 0; k < ROWS; k++)
        begin
            row_mac[k] = '0;
            row_in[k]  = '0;
            row_out[k] = '0;
        end
        rows_used  = 0;
        volume_sum = '0;
        tick_total = '0;
        period_reg = PERIOD_RESET;
        step_reg   = STEP_RESET;
    endtask

    // saturating byte counter update
    function automatic logic [CNT_W-1:0] grow_count(input logic [CNT_W-1:0] cnt,
                                                    input logic [LEN_W-1:0] len);
        logic [CNT_W:0] s;
        s = {1'b0, cnt} + len;
        return s[CNT_W] ? '1 : s[CNT_W-1:0];
    endfunction

    // row of an address, taking the next free row for a new one; -1 when full
    function automatic int find_or_take_row(input logic [MAC_W-1:0] mac);
        for (int k = 0; k < rows_used; k++)
            if (row_mac[k] == mac)
                return k;
        if (rows_used >= ROWS)
            return -1;
        row_mac[rows_used] = mac;
        row_in[rows_used]  = '0;
        row_out[rows_used] = '0;
        rows_used++;
        return rows_used - 1;
    endfunction

    // frame: destination gets the in count, then source the out count
    task automatic count_frame(input logic [MAC_W-1:0] dest, input logic [MAC_W-1:0] src,
                               input logic [LEN_W-1:0] len);
        int              r;
        logic [CNT_W:0]  sum;
        traffic_result_t mark;
        r = find_or_take_row(dest);
        if (r >= 0)
            row_in[r] = grow_count(row_in[r], len);
        r = find_or_take_row(src);
        if (r >= 0)
            row_out[r] = grow_count(row_out[r], len);
        sum = {1'b0, volume_sum} + len;
        if (sum > {1'b0, step_reg})
        begin
            sum            = sum - step_reg;
            mark.kind      = KIND_MARK;
            mark.mac       = '0;
            mark.bytes_in  = '0;
            mark.bytes_out = '0;
            mark.last      = 1'b1;
            owed_results.push_back(mark);
        end
        volume_sum = sum[CNT_W] ? '1 : sum[CNT_W-1:0];
    endtask

    // tick: a full table report once the period has run out
    task automatic count_tick();
        traffic_result_t row;
        tick_total = tick_total + 1'b1;
        if (tick_total >= period_reg)
        begin
            tick_total = tick_total - period_reg;
            for (int k = 0; k < rows_used; k++)
            begin
                row.kind      = KIND_REPORT;
                row.mac       = row_mac[k];
                row.bytes_in  = row_in[k];
                row.bytes_out = row_out[k];
                row.last      = (k == rows_used - 1);
                owed_results.push_back(row);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [MAC_W-1:0] random_mac();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // mostly addresses already in the table, some strangers
    function automatic logic [MAC_W-1:0] pick_mac();
        if (rows_used > 0 && $urandom_range(0, 99) < 75)
            return row_mac[$urandom_range(0, rows_used - 1)];
        return random_mac();
    endfunction

    function automatic logic [LEN_W-1:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 20)
            return '1;
        return LEN_W'($urandom);
    endfunction

    // one request on the input channel; called and left at a falling edge
    task automatic send_request(input logic act, input logic [MAC_W-1:0] dest,
                                input logic [MAC_W-1:0] src, input logic [LEN_W-1:0] len);
        int gap;
        gap = tight ? 0 : pick_gap();
        if (gap > 0)
        begin
            item_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_ch.action       = act;
        item_ch.dest_mac     = dest;
        item_ch.src_mac      = src;
        item_ch.frame_length = len;
        item_ch.valid        = 1'b1;
        do
            @(posedge clk);
        while (!item_ch.ready);
        if (act == ACT_TICK)
        begin
            n_ticks++;
            count_tick();
        end
        else
        begin
            n_frames++;
            count_frame(dest, src, len);
        end
        @(negedge clk);
    endtask

    // a tick with rubbish in the fields it should ignore
    task automatic send_tick();
        send_request(ACT_TICK, random_mac(), random_mac(), LEN_W'($urandom));
    endtask

    // stop sending, wait for every owed result, then let the back end settle,
    // since frames with no mark may still be in the command queue
    task automatic drain_results();
        item_ch.valid = 1'b0;
        while (owed_results.size() > 0)
            @(negedge clk);
        repeat (24) @(negedge clk);
    endtask

    // register write, only ever done with the block drained
    task automatic set_register(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
        drain_results();
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(posedge clk);
        case (idx)
            REG_REPORT_PERIOD: period_reg = value[PERIOD_W-1:0];
            REG_VOLUME_STEP:   step_reg   = value;
            default:           ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic report_mismatch(input string msg);
        n_errors++;
        if (n_errors <= 40)
            $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // ------------------------------------------------------------------
    // result side: random back-pressure and checking
    // ------------------------------------------------------------------

    initial
    begin
        int gap;
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            result_ch.ready = 1'b1;
            if (tight)
                @(negedge clk);
            else
            begin
                repeat ($urandom_range(1, 24)) @(negedge clk);
                gap = pick_gap();
                if (gap > 0 && !tight)
                begin
                    result_ch.ready = 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        traffic_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (result_ch.kind == KIND_MARK)
                n_marks++;
            else
                n_reports++;
            if (owed_results.size() == 0)
                report_mismatch($sformatf("unexpected result kind %0d mac %h",
                                          result_ch.kind, result_ch.entry_mac));
            else
            begin
                want = owed_results.pop_front();
                if (result_ch.kind !== want.kind)
                    report_mismatch($sformatf("kind %0d, wanted %0d",
                                              result_ch.kind, want.kind));
                if (result_ch.entry_mac !== want.mac)
                    report_mismatch($sformatf("entry_mac %h, wanted %h",
                                              result_ch.entry_mac, want.mac));
                if (result_ch.bytes_in !== want.bytes_in)
                    report_mismatch($sformatf("bytes_in %h, wanted %h (mac %h)",
                                              result_ch.bytes_in, want.bytes_in, want.mac));
                if (result_ch.bytes_out !== want.bytes_out)
                    report_mismatch($sformatf("bytes_out %h, wanted %h (mac %h)",
                                              result_ch.bytes_out, want.bytes_out, want.mac));
                if (result_ch.last !== want.last)
                    report_mismatch($sformatf("last %0d, wanted %0d (mac %h)",
                                              result_ch.last, want.last, want.mac));
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset period of 60 ticks runs out with nothing in the table
    task automatic test_empty_report();
        repeat (60) send_tick();
        drain_results();
    endtask

    // reset volume step: the 17th full-size frame passes it; then a report at
    // the reset period. covers all-zero and all-one addresses and a frame
    // sent to itself
    task automatic test_reset_settings();
        for (int i = 0; i < 17; i++)
            case (i % 4)
                0: send_request(ACT_FRAME, MAC_ZERO, MAC_ONES, '1);
                1: send_request(ACT_FRAME, MAC_ONES, MAC_ZERO, '1);
                2: send_request(ACT_FRAME, MAC_A, MAC_A, '1);
                default: send_request(ACT_FRAME, MAC_B, MAC_A, '1);
            endcase
        repeat (59) send_tick();
        drain_results();
        send_tick();
        drain_results();
    endtask

    // fill the table: a new address sent to itself, pairs of new addresses,
    // the last free row taken by a destination whose source is turned away,
    // then strangers that must not be counted; a report lists all rows
    task automatic test_table_full();
        logic [MAC_W-1:0] m;
        set_register(REG_REPORT_PERIOD, 32'd1);
        m = random_mac();
        send_request(ACT_FRAME, m, m, 16'd0);
        while (rows_used < ROWS)
            send_request(ACT_FRAME, random_mac(), random_mac(), pick_length());
        send_request(ACT_FRAME, random_mac(), MAC_ZERO, 16'd777);
        send_request(ACT_FRAME, MAC_B, random_mac(), 16'd4242);
        send_request(ACT_FRAME, random_mac(), random_mac(), '1);
        send_tick();
        drain_results();
    endtask

    // with a zero volume step every frame marks and nothing is taken off;
    // then the largest step, and a zero period that reports on every tick
    task automatic test_zero_settings();
        tight = 1'b1;
        set_register(REG_VOLUME_STEP, 32'd0);
        for (int i = 0; i < 6; i++)
            send_request(ACT_FRAME, MAC_ONES, MAC_ONES, '1);
        send_tick();
        drain_results();
        tight = 1'b0;
        set_register(REG_VOLUME_STEP, '1);
        send_request(ACT_FRAME, MAC_A, MAC_ZERO, 16'd100);
        set_register(REG_REPORT_PERIOD, 32'd0);
        send_tick();
        send_tick();
        drain_results();
    endtask

    // longest report period: a few ticks stay well below it
    task automatic test_long_period();
        set_register(REG_REPORT_PERIOD, 32'd65535);
        repeat (3) send_tick();
        drain_results();
    endtask

    // mixed frames and ticks over six settings, draining at each register write
    task automatic test_random_traffic();
        logic [CFG_W-1:0] step;
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0:       step = 32'd1;
                1:       step = '1;
                default: step = $urandom_range(20000, 400000);
            endcase
            set_register(REG_VOLUME_STEP, step);
            set_register(REG_REPORT_PERIOD, (p == 0) ? 32'd1 : $urandom_range(1, 5));
            for (int i = 0; i < 7; i++)
            begin
                if (p == 3 && i == 3)
                    drain_results();
                if ($urandom_range(0, 99) < 25)
                    send_tick();
                else
                    send_request(ACT_FRAME, pick_mac(), pick_mac(), pick_length());
            end
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial
    begin
        item_ch.valid        = 1'b0;
        item_ch.action       = ACT_FRAME;
        item_ch.dest_mac     = '0;
        item_ch.src_mac      = '0;
        item_ch.frame_length = '0;
        cfg_we               = 1'b0;
        cfg_index            = REG_REPORT_PERIOD;
        cfg_data             = '0;
        rst_n                = 1'b0;
        clear_shadow();
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_empty_report();
        test_reset_settings();
        test_table_full();
        test_zero_settings();
        test_long_period();
        test_random_traffic();

        drain_results();
        $display("covered %0d frames and %0d ticks, %0d volume marks and %0d row reports",
                 n_frames, n_ticks, n_marks, n_reports);
        $display("report periods 0, 1, 60 and 65535, volume steps 0, 1, reset and max, %s",
                 "full table and frames sent to their own source");
        if (n_errors == 0 && owed_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial
    begin
        #20_000_000;
        $display("timed out with %0d results outstanding", owed_results.size());
        $display("FAIL");
        $finish;
    end

endmodule
